>>> rtl/pth_sensor_compensation_core_macros.svh
// assertion macros for the sensor compensation core
// used by the top level only; expects signals named clock and reset in scope
`ifndef PTH_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define PTH_SENSOR_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define PTH_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("check failed");

// next-cycle implication
`define PTH_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("check failed");

`endif

>>> rtl/pth_pkg.sv
// shared types, constants and fixed-point helpers of the sensor compensation core
// no dependencies
`timescale 1ns / 1ps

package pth_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
      logic [2:0]  component_select;
   } req_type;

   typedef struct packed {
      logic signed [14:0] comp_temperature;
      logic [23:0]        comp_pressure;
      logic [16:0]        comp_humidity;
   } rsp_type;

   // request after the temperature stages
   typedef struct packed {
      req_type            req;
      logic signed [31:0] tfine;
      logic signed [14:0] temp;
   } tmp_type;

   // request after the humidity stages
   typedef struct packed {
      tmp_type     tmp;
      logic [16:0] hum;
   } hum_type;

   // decoded calibration coefficients
   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic [7:0]         h1;
      logic signed [15:0] h2;
      logic [7:0]         h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
   } coef_type;

   // register indexes
   localparam logic [2:0] REG_TEMP   = 3'd0;
   localparam logic [2:0] REG_PRESSA = 3'd1;
   localparam logic [2:0] REG_PRESSB = 3'd2;
   localparam logic [2:0] REG_PRESS9 = 3'd3;
   localparam logic [2:0] REG_HUM    = 3'd4;

   localparam logic signed [14:0] TEMP_MIN   = -15'sd4000;
   localparam logic signed [14:0] TEMP_MAX   = 15'sd8500;
   localparam logic [23:0]        PRESS_MIN  = 24'd3000000;
   localparam logic [23:0]        PRESS_MAX  = 24'd11000000;
   localparam logic [31:0]        HUM_RAWMAX = 32'd419430400;

   // truncating signed divide by 2**k, 32-bit
   function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
                                                 input int unsigned k);
      logic [31:0] bias;
      bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return (x + $signed(bias)) >>> k;
   endfunction

   // truncating signed divide by 2**k on a 64-bit two's complement pattern
   function automatic logic [63:0] sdiv64(input logic [63:0] x, input int unsigned k);
      logic [63:0]        bias;
      logic signed [63:0] s;
      bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
      s = $signed(x + bias);
      return $unsigned(s >>> k);
   endfunction

endpackage

>>> rtl/pth_sensor_compensation_core.sv
// Pressure, temperature and humidity compensation core.
//
// Requests come in on req_valid / req_ready / req_payload: raw temperature,
// pressure, humidity and a component select mask. Results leave on
// rsp_valid / rsp_ready / rsp_payload, one per request, in request order.
// Calibration coefficients are written over the APB port (8-byte register
// slots); the stages read them directly, so write them only while no request
// is in flight.
// On its way to the output register a request passes 4 temperature stages,
// 11 humidity stages and 85 pressure stages, of which 66 belong to the
// one-bit-per-stage pipelined divider. One request per cycle is accepted
// while the receiver keeps up.
// The output register is backed by a one-entry skid register; when the
// receiver stalls and the skid fills, req_ready drops and the whole pipeline
// holds. Reset clears all coefficients to zero and empties the pipeline.
// Pressure needs select bit 0, humidity bit 2, temperature any bit; else zero.
`timescale 1ns / 1ps
`include "pth_sensor_compensation_core_macros.svh"

module pth_sensor_compensation_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pth_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pth_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [5:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   logic [47:0] temp_ff;
   logic [63:0] pa_ff, pb_ff, hum_ff;
   logic [15:0] p9_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   pth_pkg::coef_type coef;

   logic             en;
   logic             tmp_v, hum_v, press_v;
   pth_pkg::tmp_type tmp_d;
   pth_pkg::hum_type hum_d, press_d;
   logic [23:0]      press_p;
   pth_pkg::rsp_type rsp_pipe;

   logic             rsp_v_in, rsp_v_ff, skid_v_in, skid_v_ff;
   pth_pkg::rsp_type rsp_d_in, rsp_ff, skid_d_in, skid_ff;

   logic             temp_ok, press_ok;

   // register file
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         pa_ff   <= '0;
         pb_ff   <= '0;
         p9_ff   <= '0;
         hum_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            pth_pkg::REG_TEMP:   temp_ff <= pwdata[47:0];
            pth_pkg::REG_PRESSA: pa_ff   <= pwdata;
            pth_pkg::REG_PRESSB: pb_ff   <= pwdata;
            pth_pkg::REG_PRESS9: p9_ff   <= pwdata[15:0];
            pth_pkg::REG_HUM:    hum_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         pth_pkg::REG_TEMP:   prdata = {16'd0, temp_ff};
         pth_pkg::REG_PRESSA: prdata = pa_ff;
         pth_pkg::REG_PRESSB: prdata = pb_ff;
         pth_pkg::REG_PRESS9: prdata = {48'd0, p9_ff};
         pth_pkg::REG_HUM:    prdata = hum_ff;
         default:             prdata = 64'd0;
      endcase
   end

   always_comb begin
      coef.t1 = temp_ff[15:0];
      coef.t2 = temp_ff[31:16];
      coef.t3 = temp_ff[47:32];
      coef.p1 = pa_ff[15:0];
      coef.p2 = pa_ff[31:16];
      coef.p3 = pa_ff[47:32];
      coef.p4 = pa_ff[63:48];
      coef.p5 = pb_ff[15:0];
      coef.p6 = pb_ff[31:16];
      coef.p7 = pb_ff[47:32];
      coef.p8 = pb_ff[63:48];
      coef.p9 = p9_ff;
      coef.h1 = hum_ff[7:0];
      coef.h2 = hum_ff[23:8];
      coef.h3 = hum_ff[31:24];
      coef.h4 = hum_ff[43:32];
      coef.h5 = hum_ff[55:44];
      coef.h6 = hum_ff[63:56];
   end

   // datapath; everything advances together unless the skid register is full
   assign en        = !skid_v_ff;
   assign req_ready = en;

   pth_temp u_temp (
      .clock, .reset, .en,
      .in_valid (req_valid),
      .in_req   (req_payload),
      .coef,
      .out_valid(tmp_v),
      .out_tmp  (tmp_d)
   );

   pth_hum u_hum (
      .clock, .reset, .en,
      .in_valid (tmp_v),
      .in_tmp   (tmp_d),
      .coef,
      .out_valid(hum_v),
      .out_hum  (hum_d)
   );

   pth_press u_press (
      .clock, .reset, .en,
      .in_valid (hum_v),
      .in_hum   (hum_d),
      .coef,
      .out_valid(press_v),
      .out_hum  (press_d),
      .out_press(press_p)
   );

   always_comb begin
      logic [2:0] sel;
      sel = press_d.tmp.req.component_select;
      rsp_pipe.comp_temperature = (sel == 3'd0) ? 15'sd0 : press_d.tmp.temp;
      rsp_pipe.comp_pressure    = sel[0] ? press_p : 24'd0;
      rsp_pipe.comp_humidity    = sel[2] ? press_d.hum : 17'd0;
   end

   // output register with skid
   always_comb begin
      rsp_v_in  = rsp_v_ff;
      rsp_d_in  = rsp_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_ff;
      if (skid_v_ff) begin
         if (rsp_ready) begin
            rsp_v_in  = 1'b1;
            rsp_d_in  = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!rsp_v_ff || rsp_ready) begin
         rsp_v_in = press_v;
         rsp_d_in = rsp_pipe;
      end else if (press_v) begin
         skid_v_in = 1'b1;
         skid_d_in = rsp_pipe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_d_in;
      skid_ff <= skid_d_in;
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

   assign temp_ok  = (rsp_payload.comp_temperature >= pth_pkg::TEMP_MIN)
                  && (rsp_payload.comp_temperature <= pth_pkg::TEMP_MAX);
   assign press_ok = (rsp_payload.comp_pressure == 24'd0)
                  || ((rsp_payload.comp_pressure >= pth_pkg::PRESS_MIN)
                  && (rsp_payload.comp_pressure <= pth_pkg::PRESS_MAX));

   `PTH_ASSERT_IMP(a_skid_behind_out, skid_v_ff, rsp_valid)
   `PTH_ASSERT_NXT(a_skid_catch, rsp_valid && !rsp_ready && press_v && !skid_v_ff, skid_v_ff)
   `PTH_ASSERT_IMP(a_temp_range, rsp_valid, temp_ok)
   `PTH_ASSERT_IMP(a_press_range, rsp_valid, press_ok)

endmodule

>>> rtl/pth_mul64.sv
// two-stage 64x64 multiplier, low 64 bits of the product
// built from three 32x32 partial products; no package use
`timescale 1ns / 1ps

module pth_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic [63:0] prod
);

   logic [63:0] ll_in, ll_ff;
   logic [31:0] lh_in, lh_ff, hl_in, hl_ff;
   logic [63:0] prod_in, prod_ff;

   assign ll_in   = x[31:0] * y[31:0];
   assign lh_in   = x[31:0] * y[63:32];
   assign hl_in   = x[63:32] * y[31:0];
   assign prod_in = ll_ff + {lh_ff + hl_ff, 32'd0};
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         prod_ff <= prod_in;
      end
   end

endmodule

>>> rtl/pth_div.sv
// pipelined signed 64-bit divider, truncating, one quotient bit per stage
// stages: sign strip, 64 restoring steps, sign fix; no package use
`timescale 1ns / 1ps

module pth_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quo
);

   localparam int unsigned STEPS = 64;

   logic [63:0] rem_in [STEPS+1];
   logic [63:0] rem_ff [STEPS+1];
   logic [63:0] qn_in  [STEPS+1];
   logic [63:0] qn_ff  [STEPS+1];
   logic [63:0] dv_in  [STEPS+1];
   logic [63:0] dv_ff  [STEPS+1];
   logic        ng_in  [STEPS+1];
   logic        ng_ff  [STEPS+1];
   logic [63:0] quo_in, quo_ff;

   always_comb begin
      logic [64:0] trial;
      rem_in[0] = 64'd0;
      qn_in[0]  = num[63] ? (64'd0 - num) : num;
      dv_in[0]  = den[63] ? (64'd0 - den) : den;
      ng_in[0]  = num[63] ^ den[63];
      for (int k = 1; k <= STEPS; k++) begin
         trial = {rem_ff[k-1], qn_ff[k-1][63]};
         dv_in[k] = dv_ff[k-1];
         ng_in[k] = ng_ff[k-1];
         if (trial >= {1'b0, dv_ff[k-1]}) begin
            rem_in[k] = trial[63:0] - dv_ff[k-1];
            qn_in[k]  = {qn_ff[k-1][62:0], 1'b1};
         end else begin
            rem_in[k] = trial[63:0];
            qn_in[k]  = {qn_ff[k-1][62:0], 1'b0};
         end
      end
      quo_in = ng_ff[STEPS] ? (64'd0 - qn_ff[STEPS]) : qn_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            qn_ff[k]  <= qn_in[k];
            dv_ff[k]  <= dv_in[k];
            ng_ff[k]  <= ng_in[k];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

>>> rtl/pth_temp.sv
// temperature stages: fine temperature and clamped 0.01 degC value
// uses pth_pkg types and divide helpers
`timescale 1ns / 1ps

module pth_temp (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pth_pkg::req_type  in_req,
   input  pth_pkg::coef_type coef,
   output logic              out_valid,
   output pth_pkg::tmp_type  out_tmp
);

   localparam int unsigned LAT = 4;

   logic [LAT-1:0]   v_ff;
   pth_pkg::req_type rq_ff [LAT];

   logic signed [31:0] m1_in, m1_ff, m2_in, m2_ff;
   logic signed [31:0] v1_in, v1_ff, m3_in, m3_ff;
   logic signed [31:0] tf_in, tf_ff, tfo_ff;
   logic signed [14:0] ct_in, ct_ff;

   always_comb begin
      logic signed [31:0] va, vb, x, t;
      va = $signed({15'd0, in_req.raw_temperature[19:3]})
         - $signed({15'd0, coef.t1, 1'b0});
      vb = $signed({16'd0, in_req.raw_temperature[19:4]}) - $signed({16'd0, coef.t1});
      m1_in = va * 32'(coef.t2);
      m2_in = vb * vb;
      v1_in = pth_pkg::sdiv32(m1_ff, 11);
      m3_in = pth_pkg::sdiv32(m2_ff, 12) * 32'(coef.t3);
      tf_in = v1_ff + pth_pkg::sdiv32(m3_ff, 14);
      x = (tf_ff <<< 2) + tf_ff + 32'sd128;
      t = pth_pkg::sdiv32(x, 8);
      if (t < 32'(pth_pkg::TEMP_MIN)) begin
         ct_in = pth_pkg::TEMP_MIN;
      end else if (t > 32'(pth_pkg::TEMP_MAX)) begin
         ct_in = pth_pkg::TEMP_MAX;
      end else begin
         ct_in = t[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rq_ff[0] <= in_req;
         for (int k = 1; k < LAT; k++) begin
            rq_ff[k] <= rq_ff[k-1];
         end
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         v1_ff  <= v1_in;
         m3_ff  <= m3_in;
         tf_ff  <= tf_in;
         tfo_ff <= tf_ff;
         ct_ff  <= ct_in;
      end
   end

   assign out_valid = v_ff[LAT-1];

   always_comb begin
      out_tmp.req   = rq_ff[LAT-1];
      out_tmp.tfine = tfo_ff;
      out_tmp.temp  = ct_ff;
   end

endmodule

>>> rtl/pth_hum.sv
// humidity stages: 1/1024 %RH from raw humidity and fine temperature
// uses pth_pkg types and divide helpers
`timescale 1ns / 1ps

module pth_hum (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pth_pkg::tmp_type  in_tmp,
   input  pth_pkg::coef_type coef,
   output logic              out_valid,
   output pth_pkg::hum_type  out_hum
);

   localparam int unsigned LAT = 11;

   logic [LAT-1:0]   v_ff;
   pth_pkg::tmp_type tp_ff [LAT];

   logic signed [31:0] v1_in, v1_ff;
   logic signed [31:0] ma_in, ma_ff, mb_in, mb_ff, mc_in, mc_ff;
   logic signed [31:0] v5_in, v5_ff, v2p_in, v2p_ff, v3p_in, v3p_ff;
   logic signed [31:0] md_in, md_ff, v5b_ff;
   logic signed [31:0] v4p_in, v4p_ff, v5c_ff;
   logic signed [31:0] me_in, me_ff, v5d_ff;
   logic signed [31:0] mf_in, mf_ff;
   logic signed [31:0] s_in, s_ff, mfb_ff;
   logic signed [31:0] mg_in, mg_ff, mfc_ff;
   logic signed [31:0] mh_in, mh_ff, mfd_ff;
   logic [16:0]        ch_in, ch_ff;

   always_comb begin
      logic signed [31:0] acc, hv;
      logic [31:0]        hc;
      v1_in = in_tmp.tfine - 32'sd76800;
      ma_in = 32'(coef.h5) * v1_ff;
      mb_in = v1_ff * 32'(coef.h6);
      mc_in = v1_ff * $signed({24'd0, coef.h3});
      acc = $signed({2'd0, tp_ff[1].req.raw_humidity, 14'd0}) - $signed({coef.h4, 20'd0})
          - ma_ff + 32'sd16384;
      v5_in  = pth_pkg::sdiv32(acc, 15);
      v2p_in = pth_pkg::sdiv32(mb_ff, 10);
      v3p_in = pth_pkg::sdiv32(mc_ff, 11) + 32'sd32768;
      md_in  = v2p_ff * v3p_ff;
      v4p_in = pth_pkg::sdiv32(md_ff, 10) + 32'sd2097152;
      me_in  = v4p_ff * 32'(coef.h2) + 32'sd8192;
      mf_in  = v5d_ff * pth_pkg::sdiv32(me_ff, 14);
      s_in   = pth_pkg::sdiv32(mf_ff, 15);
      mg_in  = s_ff * s_ff;
      mh_in  = pth_pkg::sdiv32(mg_ff, 7) * $signed({24'd0, coef.h1});
      hv = mfd_ff - pth_pkg::sdiv32(mh_ff, 4);
      if (hv[31]) begin
         hc = 32'd0;
      end else if ($unsigned(hv) > pth_pkg::HUM_RAWMAX) begin
         hc = pth_pkg::HUM_RAWMAX;
      end else begin
         hc = $unsigned(hv);
      end
      ch_in = hc[28:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tp_ff[0] <= in_tmp;
         for (int k = 1; k < LAT; k++) begin
            tp_ff[k] <= tp_ff[k-1];
         end
         v1_ff  <= v1_in;
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         mc_ff  <= mc_in;
         v5_ff  <= v5_in;
         v2p_ff <= v2p_in;
         v3p_ff <= v3p_in;
         md_ff  <= md_in;
         v5b_ff <= v5_ff;
         v4p_ff <= v4p_in;
         v5c_ff <= v5b_ff;
         me_ff  <= me_in;
         v5d_ff <= v5c_ff;
         mf_ff  <= mf_in;
         s_ff   <= s_in;
         mfb_ff <= mf_ff;
         mg_ff  <= mg_in;
         mfc_ff <= mfb_ff;
         mh_ff  <= mh_in;
         mfd_ff <= mfc_ff;
         ch_ff  <= ch_in;
      end
   end

   assign out_valid = v_ff[LAT-1];

   always_comb begin
      out_hum.tmp = tp_ff[LAT-1];
      out_hum.hum = ch_ff;
   end

endmodule

>>> rtl/pth_press.sv
// pressure stages: 64-bit compensation with pipelined divider
// uses pth_pkg, pth_mul64 and pth_div
`timescale 1ns / 1ps

module pth_press (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pth_pkg::hum_type  in_hum,
   input  pth_pkg::coef_type coef,
   output logic              out_valid,
   output pth_pkg::hum_type  out_hum,
   output logic [23:0]       out_press
);

   localparam int unsigned LAT   = 85;
   // divisor zero flag travels from the stage after the divisor to the last stage
   localparam int unsigned DZLEN = 74;

   logic [LAT-1:0]   v_ff;
   pth_pkg::hum_type hd_ff [LAT];
   logic [DZLEN-1:0] dz_ff;

   logic [63:0] a_in, a_ff;
   logic [63:0] aa, ap5, ap2, aap6, aap3;
   logic [63:0] ap5b_ff, ap2b_ff, ap5c_ff, ap2c_ff;
   logic [63:0] b_in, b_ff, a2_in, a2_ff;
   logic [63:0] a2b_in, a2b_ff, np_in, np_ff;
   logic [63:0] m6, m7;
   logic [63:0] a3_in, a3_ff, nm_ff;
   logic [63:0] q, sq;
   logic [63:0] m8, m9, m10, m11;
   logic [63:0] d77_ff, d78_ff, d79_ff, d80_ff;
   logic [63:0] e79_in, e79_ff, e80_ff;
   logic [63:0] ds_in, ds_ff, dp_in, dp_ff, dh;
   logic [23:0] pr_in, pr_ff;

   always_comb begin
      logic [63:0] pw;
      a_in  = 64'(in_hum.tmp.tfine) - 64'd128000;
      b_in  = aap6 + (ap5c_ff << 17) + (64'(coef.p4) << 35);
      a2_in = pth_pkg::sdiv64(aap3, 8) + (ap2c_ff << 12);
      a2b_in = a2_ff + 64'd140737488355328;
      np_in = ((64'd1048576 - 64'(hd_ff[5].tmp.req.raw_pressure)) << 31) - b_ff;
      a3_in = pth_pkg::sdiv64(m6, 33);
      sq    = pth_pkg::sdiv64(q, 13);
      e79_in = pth_pkg::sdiv64(m9, 19);
      ds_in = d80_ff + pth_pkg::sdiv64(m10, 25) + e80_ff;
      dp_in = pth_pkg::sdiv64(ds_ff, 8) + (64'(coef.p7) << 4);
      dh    = pth_pkg::sdiv64(dp_ff, 1);
      pw    = pth_pkg::sdiv64(m11, 7);
      // zero divisor reads as the lower limit
      if (dz_ff[DZLEN-1] || (pw[31:0] < 32'(pth_pkg::PRESS_MIN))) begin
         pr_in = pth_pkg::PRESS_MIN;
      end else if (pw[31:0] > 32'(pth_pkg::PRESS_MAX)) begin
         pr_in = pth_pkg::PRESS_MAX;
      end else begin
         pr_in = pw[23:0];
      end
   end

   pth_mul64 u_aa   (.clock, .en, .x(a_ff), .y(a_ff), .prod(aa));
   pth_mul64 u_ap5  (.clock, .en, .x(a_ff), .y(64'(coef.p5)), .prod(ap5));
   pth_mul64 u_ap2  (.clock, .en, .x(a_ff), .y(64'(coef.p2)), .prod(ap2));
   pth_mul64 u_aap6 (.clock, .en, .x(aa), .y(64'(coef.p6)), .prod(aap6));
   pth_mul64 u_aap3 (.clock, .en, .x(aa), .y(64'(coef.p3)), .prod(aap3));
   pth_mul64 u_m6   (.clock, .en, .x(a2b_ff), .y(64'(coef.p1)), .prod(m6));
   pth_mul64 u_m7   (.clock, .en, .x(np_ff), .y(64'd3125), .prod(m7));

   pth_div u_div (.clock, .en, .num(nm_ff), .den(a3_ff), .quo(q));

   pth_mul64 u_m8   (.clock, .en, .x(sq), .y(sq), .prod(m8));
   pth_mul64 u_m9   (.clock, .en, .x(64'(coef.p8)), .y(q), .prod(m9));
   pth_mul64 u_m10  (.clock, .en, .x(m8), .y(64'(coef.p9)), .prod(m10));
   pth_mul64 u_m11  (.clock, .en, .x(dh), .y(64'd100), .prod(m11));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hd_ff[0] <= in_hum;
         for (int k = 1; k < LAT; k++) begin
            hd_ff[k] <= hd_ff[k-1];
         end
         dz_ff   <= {dz_ff[DZLEN-2:0], (a3_ff == 64'd0)};
         a_ff    <= a_in;
         ap5b_ff <= ap5;
         ap2b_ff <= ap2;
         ap5c_ff <= ap5b_ff;
         ap2c_ff <= ap2b_ff;
         b_ff    <= b_in;
         a2_ff   <= a2_in;
         a2b_ff  <= a2b_in;
         np_ff   <= np_in;
         a3_ff   <= a3_in;
         nm_ff   <= m7;
         d77_ff  <= q;
         d78_ff  <= d77_ff;
         d79_ff  <= d78_ff;
         d80_ff  <= d79_ff;
         e79_ff  <= e79_in;
         e80_ff  <= e79_ff;
         ds_ff   <= ds_in;
         dp_ff   <= dp_in;
         pr_ff   <= pr_in;
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign out_hum   = hd_ff[LAT-1];
   assign out_press = pr_ff;

endmodule

>>> verif/tb_top.sv
// self-checking testbench of the sensor compensation core: an internal predictor
// of the fixed-point formulas is checked against every result; uses pth_pkg and the core
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY     = 100;
   localparam int STALL_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pth_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   pth_pkg::rsp_type rsp_payload;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [5:0]       paddr;
   logic [63:0]      pwdata;
   logic [63:0]      prdata;
   logic             pready;

   // shadow copy of the calibration registers
   logic [47:0] temp_cal;
   logic [63:0] press_cal_a;
   logic [63:0] press_cal_b;
   logic [15:0] press_cal_nine;
   logic [63:0] hum_cal;

   pth_pkg::rsp_type expected_results[$];
   int               error_count;
   int               idle_cycles;
   bit               idling_on;

   pth_sensor_compensation_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // sign-extend the low bits of a pattern
   function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
      logic signed [63:0] s;
      s = $signed(v << (64 - bits));
      return $unsigned(s >>> (64 - bits));
   endfunction

   function automatic logic [63:0] w32(input logic [63:0] v);
      return sx(v, 32);
   endfunction

   // signed division truncating toward zero, zero for a zero divisor
   function automatic logic [63:0] div_tz(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      if (mb == 64'd0) return 64'd0;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic pth_pkg::rsp_type compensate_sample(input pth_pkg::req_type r);
      pth_pkg::rsp_type   res;
      logic [63:0]        rt, rp, rh, t1, t2, t3, v1, v2, v3, v4, v5, tf;
      logic [63:0]        p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, c, d, e;
      logic [63:0]        h1, h2, h3, h4, h5, h6;
      logic [31:0]        pr;
      logic signed [63:0] ts, hs;
      res = '0;
      if (r.component_select == 3'd0) return res;
      rt = 64'(r.raw_temperature);
      rp = 64'(r.raw_pressure);
      rh = 64'(r.raw_humidity);
      t1 = 64'(temp_cal[15:0]);
      t2 = sx(64'(temp_cal[31:16]), 16);
      t3 = sx(64'(temp_cal[47:32]), 16);
      v1 = w32(rt / 8 - t1 * 2);
      v1 = w32(div_tz(w32(v1 * t2), 64'd2048));
      v2 = w32(rt / 16 - t1);
      v2 = w32(div_tz(w32(v2 * v2), 64'd4096));
      v2 = w32(div_tz(w32(v2 * t3), 64'd16384));
      tf = w32(v1 + v2);
      ts = $signed(w32(div_tz(w32(tf * 5 + 64'd128), 64'd256)));
      if (ts < -4000) ts = -4000;
      else if (ts > 8500) ts = 8500;
      res.comp_temperature = ts[14:0];

      if (r.component_select[0]) begin
         p1 = 64'(press_cal_a[15:0]);
         p2 = sx(64'(press_cal_a[31:16]), 16);
         p3 = sx(64'(press_cal_a[47:32]), 16);
         p4 = sx(64'(press_cal_a[63:48]), 16);
         p5 = sx(64'(press_cal_b[15:0]), 16);
         p6 = sx(64'(press_cal_b[31:16]), 16);
         p7 = sx(64'(press_cal_b[47:32]), 16);
         p8 = sx(64'(press_cal_b[63:48]), 16);
         p9 = sx(64'(press_cal_nine), 16);
         a = tf - 64'd128000;
         b = a * a * p6;
         b = b + a * p5 * 64'd131072;
         b = b + p4 * 64'd34359738368;
         a = div_tz(a * a * p3, 64'd256) + a * p2 * 64'd4096;
         a = div_tz((64'd140737488355328 + a) * p1, 64'd8589934592);
         if (a != 64'd0) begin
            d = 64'd1048576 - rp;
            d = div_tz((d * 64'd2147483648 - b) * 64'd3125, a);
            c = div_tz(p9 * div_tz(d, 64'd8192) * div_tz(d, 64'd8192), 64'd33554432);
            e = div_tz(p8 * d, 64'd524288);
            d = div_tz(d + c + e, 64'd256) + p7 * 16;
            pr = 32'(div_tz(div_tz(d, 64'd2) * 100, 64'd128));
            if (pr < 32'd3000000) pr = 32'd3000000;
            else if (pr > 32'd11000000) pr = 32'd11000000;
         end else begin
            pr = 32'd3000000;
         end
         res.comp_pressure = pr[23:0];
      end

      if (r.component_select[2]) begin
         h1 = 64'(hum_cal[7:0]);
         h2 = sx(64'(hum_cal[23:8]), 16);
         h3 = 64'(hum_cal[31:24]);
         h4 = sx(64'(hum_cal[43:32]), 12);
         h5 = sx(64'(hum_cal[55:44]), 12);
         h6 = sx(64'(hum_cal[63:56]), 8);
         v1 = w32(tf - 64'd76800);
         v2 = w32(rh * 64'd16384);
         v3 = w32(h4 * 64'd1048576);
         v4 = w32(h5 * v1);
         v5 = w32(div_tz(w32(v2 - v3 - v4 + 64'd16384), 64'd32768));
         v2 = w32(div_tz(w32(v1 * h6), 64'd1024));
         v3 = w32(div_tz(w32(v1 * h3), 64'd2048));
         v4 = w32(div_tz(w32(v2 * w32(v3 + 64'd32768)), 64'd1024) + 64'd2097152);
         v2 = w32(div_tz(w32(v4 * h2 + 64'd8192), 64'd16384));
         v3 = w32(v5 * v2);
         v4 = w32(div_tz(w32(div_tz(v3, 64'd32768) * div_tz(v3, 64'd32768)), 64'd128));
         v5 = w32(v3 - div_tz(w32(v4 * h1), 64'd16));
         hs = $signed(v5);
         if (hs < 0) hs = 0;
         if (hs > 419430400) hs = 419430400;
         hs = hs / 4096;
         if (hs > 102400) hs = 102400;
         res.comp_humidity = hs[16:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_payload), 32'd0);
         end else begin
            pth_pkg::rsp_type want;
            want = expected_results.pop_front();
            if (rsp_payload.comp_temperature !== want.comp_temperature)
               report_mismatch("temperature", 32'(rsp_payload.comp_temperature),
                               32'(want.comp_temperature));
            if (rsp_payload.comp_pressure !== want.comp_pressure)
               report_mismatch("pressure", 32'(rsp_payload.comp_pressure),
                               32'(want.comp_pressure));
            if (rsp_payload.comp_humidity !== want.comp_humidity)
               report_mismatch("humidity", 32'(rsp_payload.comp_humidity),
                               32'(want.comp_humidity));
         end
      end
   end

   // watchdog on cycles without any accepted request or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver stalls in bursts while idling is on
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         pth_pkg::REG_TEMP:   temp_cal       = value[47:0];
         pth_pkg::REG_PRESSA: press_cal_a    = value;
         pth_pkg::REG_PRESSB: press_cal_b    = value;
         pth_pkg::REG_PRESS9: press_cal_nine = value[15:0];
         pth_pkg::REG_HUM:    hum_cal        = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [63:0] t, input logic [63:0] pa,
                                   input logic [63:0] pb, input logic [63:0] p9,
                                   input logic [63:0] h);
      drain();
      write_reg(pth_pkg::REG_TEMP, t);
      write_reg(pth_pkg::REG_PRESSA, pa);
      write_reg(pth_pkg::REG_PRESSB, pb);
      write_reg(pth_pkg::REG_PRESS9, p9);
      write_reg(pth_pkg::REG_HUM, h);
   endtask

   task automatic send_sample(input pth_pkg::req_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(compensate_sample(r));
   endtask

   function automatic pth_pkg::req_type random_sample();
      pth_pkg::req_type r;
      r.raw_temperature  = $urandom_range(0, 1048575);
      r.raw_pressure     = $urandom_range(0, 1048575);
      r.raw_humidity     = $urandom_range(0, 65535);
      r.component_select = $urandom_range(0, 7);
      // mostly readings near a plausible operating point
      if ($urandom_range(0, 2) != 0) begin
         r.raw_temperature = $urandom_range(400000, 600000);
         r.raw_pressure    = $urandom_range(250000, 500000);
         r.raw_humidity    = $urandom_range(20000, 40000);
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic load_nominal;
      load_calibration({16'hFC18, 16'd26435, 16'd27504},
                       {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                       {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                       64'd6000,
                       {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
   endtask

   // all coefficients zero after reset: pressure divisor is zero
   task automatic test_reset_values;
      pth_pkg::req_type r;
      for (int s = 0; s < 8; s++) begin
         r = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148,
               raw_humidity: 16'd30000, component_select: 3'(s)};
         send_sample(r);
      end
   endtask

   task automatic test_directed;
      pth_pkg::req_type r;
      load_nominal();
      for (int s = 0; s < 8; s++) begin
         r = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148,
               raw_humidity: 16'd31000, component_select: 3'(s)};
         send_sample(r);
      end
      send_sample('{20'd0, 20'd0, 16'd0, 3'd7});
      send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 3'd7});
      send_sample('{20'd0, 20'hFFFFF, 16'hFFFF, 3'd7});
      send_sample('{20'hFFFFF, 20'd0, 16'd0, 3'd7});
      send_sample('{20'd300000, 20'd100000, 16'd60000, 3'd7});
      send_sample('{20'd700000, 20'd600000, 16'd1000, 3'd5});
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) send_sample(random_sample());
   endtask

   task automatic test_random_settings;
      load_nominal();
      run_random(250);
      // extremes of every register
      load_calibration('1, '1, '1, '1, '1);
      run_random(150);
      load_calibration(64'h7FFF_7FFF_7FFF, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF,
                       {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
      run_random(150);
      load_calibration(64'h8000_8000_0000, {{3{16'h8000}}, 16'h0000}, {4{16'h8000}},
                       64'h8000, {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
      run_random(150);
      load_calibration(rand64(), rand64(), rand64(), rand64(), rand64());
      run_random(200);
      load_calibration('0, '0, '0, '0, '0);
      run_random(100);
   endtask

   task automatic test_no_idling;
      load_nominal();
      idling_on = 1'b0;
      run_random(350);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      error_count = 0;
      idle_cycles = 0;
      idling_on   = 1'b1;
      temp_cal       = '0;
      press_cal_a    = '0;
      press_cal_b    = '0;
      press_cal_nine = '0;
      hum_cal        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed();
      test_random_settings();
      test_no_idling();

      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
